@@ rtl/core/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants for the PID step block: register map,
// configuration bundle and per-step result bundle.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// Field widths
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned ERR_W   = DATA_W + 1;
	localparam int unsigned DIF_W   = DATA_W + 2;
	localparam int unsigned INDEX_W = 3;

	// Register map
	typedef enum logic [INDEX_W-1:0] {
		REG_GAIN_PROP   = 3'd0,
		REG_GAIN_INTEG  = 3'd1,
		REG_GAIN_DERIV  = 3'd2,
		REG_INTEG_UPPER = 3'd3,
		REG_INTEG_LOWER = 3'd4,
		REG_DRIVE_UPPER = 3'd5,
		REG_DRIVE_LOWER = 3'd6,
		REG_PERIOD_MS   = 3'd7
	} reg_index_t;

	// Reset values
	localparam logic [DATA_W-1:0] RST_GAIN_PROP   = 16'h0100;
	localparam logic [DATA_W-1:0] RST_GAIN_INTEG  = 16'h0000;
	localparam logic [DATA_W-1:0] RST_GAIN_DERIV  = 16'h0000;
	localparam logic [DATA_W-1:0] RST_LIMIT_UPPER = 16'h7FFF;
	localparam logic [DATA_W-1:0] RST_LIMIT_LOWER = 16'h8000;
	localparam logic [DATA_W-1:0] RST_PERIOD_MS   = 16'd10;

	// Current register contents, as seen by the datapath
	typedef struct packed {
		logic signed [DATA_W-1:0] gain_prop;
		logic signed [DATA_W-1:0] gain_integ;
		logic signed [DATA_W-1:0] gain_deriv;
		logic signed [DATA_W-1:0] integ_upper;
		logic signed [DATA_W-1:0] integ_lower;
		logic signed [DATA_W-1:0] drive_upper;
		logic signed [DATA_W-1:0] drive_lower;
		logic        [DATA_W-1:0] period_ms;
	} cfg_t;

	// One control step result
	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic signed [DATA_W-1:0] integ_now;
		logic                     saturated;
	} step_res_t;

endpackage

@@ rtl/core/pidc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pidc_cfg_regs
// Configuration register file: gains, integrator clamps, drive limits and
// sample period. Write-only, one register per write.
// ----------------------------------------------------------------------------
module pidc_cfg_regs
	import pidc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]  cfg_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop   <= RST_GAIN_PROP;
			cfg_q.gain_integ  <= RST_GAIN_INTEG;
			cfg_q.gain_deriv  <= RST_GAIN_DERIV;
			cfg_q.integ_upper <= RST_LIMIT_UPPER;
			cfg_q.integ_lower <= RST_LIMIT_LOWER;
			cfg_q.drive_upper <= RST_LIMIT_UPPER;
			cfg_q.drive_lower <= RST_LIMIT_LOWER;
			cfg_q.period_ms   <= RST_PERIOD_MS;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_GAIN_PROP:   cfg_q.gain_prop   <= cfg_data;
				REG_GAIN_INTEG:  cfg_q.gain_integ  <= cfg_data;
				REG_GAIN_DERIV:  cfg_q.gain_deriv  <= cfg_data;
				REG_INTEG_UPPER: cfg_q.integ_upper <= cfg_data;
				REG_INTEG_LOWER: cfg_q.integ_lower <= cfg_data;
				REG_DRIVE_UPPER: cfg_q.drive_upper <= cfg_data;
				REG_DRIVE_LOWER: cfg_q.drive_lower <= cfg_data;
				REG_PERIOD_MS:   cfg_q.period_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/pidc_core.sv @@
// ----------------------------------------------------------------------------
// pidc_core
// Control step datapath and controller state: step gating on elapsed time,
// error, clamped integrator, P + I + D sum, rounding and drive saturation.
// ----------------------------------------------------------------------------
module pidc_core
	import pidc_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     fire,
	input  logic [TIME_W-1:0]        time_ms,
	input  logic signed [DATA_W-1:0] measured,
	input  logic signed [DATA_W-1:0] target,
	output logic                     step,
	output step_res_t                res
);

	// Integrator, product, pre-clamp accumulator and drive sum widths; rounding constant
	localparam int unsigned INT_W  = DATA_W + FRAC_BITS;
	localparam int unsigned PI_W   = DATA_W + ERR_W;
	localparam int unsigned PD_W   = DATA_W + DIF_W;
	localparam int unsigned IACC_W = ((INT_W > PI_W) ? INT_W : PI_W) + 1;
	localparam int unsigned SUM_W  = ((INT_W > PD_W) ? INT_W : PD_W) + 2;
	localparam int unsigned RND    = (2 ** FRAC_BITS) / 2;

	logic signed [INT_W-1:0]  integ_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic        [TIME_W-1:0] last_time_q;
	logic                     first_q;

	logic        [TIME_W-1:0] elapsed;
	logic signed [ERR_W-1:0]  err;
	logic signed [DIF_W-1:0]  dif;
	logic signed [PI_W-1:0]   prod_i;
	logic signed [PI_W-1:0]   prod_p;
	logic signed [PD_W-1:0]   prod_d;
	logic signed [IACC_W-1:0] iacc;
	logic signed [IACC_W-1:0] ihi;
	logic signed [IACC_W-1:0] ilo;
	logic signed [IACC_W-1:0] iclamp_hi;
	logic signed [IACC_W-1:0] iclamp;
	logic signed [INT_W-1:0]  integ_next;
	logic signed [INT_W-1:0]  integ_int;
	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  drv_full;
	logic signed [SUM_W-1:0]  dhi;
	logic signed [SUM_W-1:0]  dlo;
	logic signed [SUM_W-1:0]  drv_hi;
	logic signed [SUM_W-1:0]  drv_sat;

	// Step gating: first item after reset, or period elapsed (mod 2^32)
	assign elapsed = time_ms - last_time_q;
	assign step    = first_q || (elapsed >= TIME_W'(cfg.period_ms));

	// Error terms
	assign err = ERR_W'(target) - ERR_W'(measured);
	assign dif = DIF_W'(err) - DIF_W'(prev_err_q);

	// Three independent products
	assign prod_i = cfg.gain_integ * err;
	assign prod_p = cfg.gain_prop * err;
	assign prod_d = cfg.gain_deriv * dif;

	// Integrator update and clamp; lower limit wins when limits cross
	always_comb begin
		iacc      = IACC_W'(integ_q) + IACC_W'(prod_i);
		ihi       = IACC_W'(cfg.integ_upper) <<< FRAC_BITS;
		ilo       = IACC_W'(cfg.integ_lower) <<< FRAC_BITS;
		iclamp_hi = (iacc > ihi) ? ihi : iacc;
		iclamp    = (iclamp_hi < ilo) ? ilo : iclamp_hi;
	end

	assign integ_next = iclamp[INT_W-1:0];
	assign integ_int  = integ_next >>> FRAC_BITS;

	// P + I + D, round half up, then floor to integer
	always_comb begin
		total    = SUM_W'(prod_p) + SUM_W'(integ_next) + SUM_W'(prod_d) + SUM_W'(RND);
		drv_full = total >>> FRAC_BITS;
		dhi      = SUM_W'(cfg.drive_upper);
		dlo      = SUM_W'(cfg.drive_lower);
		drv_hi   = (drv_full > dhi) ? dhi : drv_full;
		drv_sat  = (drv_hi < dlo) ? dlo : drv_hi;
	end

	assign res.drive     = drv_sat[DATA_W-1:0];
	assign res.integ_now = integ_int[DATA_W-1:0];
	assign res.saturated = (drv_full > dhi) || (drv_hi < dlo);

	// Controller state, updated only by an item that steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_err_q  <= '0;
			last_time_q <= '0;
			first_q     <= 1'b1;
		end else if (fire && step) begin
			integ_q     <= integ_next;
			prev_err_q  <= err;
			last_time_q <= time_ms;
			first_q     <= 1'b0;
		end
	end

endmodule

@@ rtl/core/pid_step_with_integral_clamp.sv @@
// ----------------------------------------------------------------------------
// pid_step_with_integral_clamp
// PID controller step with integrator clamp and drive saturation.
//
//   port group   dir  handshake           payload
//   input        in   in_valid/in_ready   time_ms, measured, target
//   result       out  out_valid/out_ready drive, integ_now, drive_saturated
//   config       in   cfg_we              cfg_index, cfg_data
//
// One transaction per cycle while the result is not stalled: an accepted
// transaction is held in the input register, the step is evaluated in one
// pass and the result lands in the output register once it can take it.
// Transactions that do not step are dropped without producing a result.
// Reset clears controller state and loads register defaults.
// A stalled result holds the input register; input ready follows.
// ----------------------------------------------------------------------------
module pid_step_with_integral_clamp
	import pidc_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [TIME_W-1:0]        time_ms,
	input  logic signed [DATA_W-1:0] measured,
	input  logic signed [DATA_W-1:0] target,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] drive,
	output logic signed [DATA_W-1:0] integ_now,
	output logic                     drive_saturated,
	input  logic                     cfg_we,
	input  logic [INDEX_W-1:0]       cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	cfg_t      cfg;
	step_res_t res;
	logic      step;
	logic      advance;

	logic                     valid_s1;
	logic [TIME_W-1:0]        time_s1;
	logic signed [DATA_W-1:0] meas_s1;
	logic signed [DATA_W-1:0] targ_s1;

	logic      valid_s2;
	step_res_t res_s2;

	pidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Flow control
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_s1 <= time_ms;
			meas_s1 <= measured;
			targ_s1 <= target;
		end
	end

	pidc_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.fire     (advance),
		.time_ms  (time_s1),
		.measured (meas_s1),
		.target   (targ_s1),
		.step     (step),
		.res      (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign drive           = res_s2.drive;
	assign integ_now       = res_s2.integ_now;
	assign drive_saturated = res_s2.saturated;

endmodule
